### src/bfg_pkg.sv
// Shared constants, types and the x^1.1 breakpoint table for the battery fuel gauge.
// Used by bfg_mul, bfg_div and battery_fuel_gauge_model; no dependencies.
`default_nettype none

package bfg_pkg;

   // Power table geometry
   localparam int POWER_TABLE_SEGMENTS = 64;
   localparam int IDX_W = $clog2(POWER_TABLE_SEGMENTS + 1);
   localparam int Y_W = 24;                 // breakpoints in Q16.16, below 2^24

   // Shared multiplier operand and product widths
   localparam int A_W = 25;
   localparam int B_W = 24;
   localparam int P_W = A_W + B_W;

   // Shared divider widths
   localparam int DIVIDEND_W = 53;
   localparam int DIVISOR_W = 38;
   localparam int DIV_CNT_W = $clog2(DIVIDEND_W + 1);

   // Field widths
   localparam int CUR_W = 16;
   localparam int DT_W = 20;
   localparam int RES_W = 20;
   localparam int CAP_W = 16;
   localparam int MV_W = 14;
   localparam int CHG_W = 25;
   localparam int OCV_W = 48;

   localparam logic [CHG_W-1:0] FULL_CHARGE = 25'd16777216;

   // Open-circuit voltage in 2^-24 mV units, scaled by 1000
   localparam logic [OCV_W-1:0] OCV_BASE_HI = 48'd188743680000000;
   localparam logic [OCV_W-1:0] OCV_BASE_LO = 48'd150994944000000;
   localparam logic [B_W-1:0] OCV_SLOPE_HI = 24'd750000;
   localparam logic [B_W-1:0] OCV_SLOPE_LO = 24'd12000000;

   // mV rounding: add half a unit, drop 24 bits, then divide by 1000 as a
   // multiply by ceil(2^34/1000); exact for the 24-bit operand range
   localparam logic [OCV_W-1:0] MV_HALF = 48'd8388608000;
   localparam logic [A_W-1:0] MV_RECIP = 25'd17179870;
   localparam int MV_RECIP_SHIFT = 34;
   localparam logic [A_W-1:0] HOUR_MS = 25'd3600000;

   // Register map
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 20;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESISTANCE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPACITY = 2'd1;

   typedef struct packed {
      logic start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

   typedef logic [Y_W-1:0] power_table_type [0:POWER_TABLE_SEGMENTS];

   // Breakpoint k holds (k*128/S)^1.1 in Q16.16: a * a^0.1, the tenth root found by
   // bisection over Q24 values with truncated powers.
   function automatic power_table_type build_power_table();
      power_table_type tab;
      logic [63:0] a;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      logic [63:0] p;
      int k;
      int i;
      for (k = 0; k <= POWER_TABLE_SEGMENTS; k++) begin
         a = (64'(k) << 31) / 64'(POWER_TABLE_SEGMENTS);
         lo = 64'd0;
         hi = 64'd1 << 25;
         while (hi - lo > 64'd1) begin
            mid = (lo + hi) >> 1;
            p = mid;
            for (i = 0; i < 9; i++) begin
               p = (p * mid) >> 24;
            end
            if (p <= a) begin
               lo = mid;
            end else begin
               hi = mid;
            end
         end
         tab[k] = Y_W'((a * lo) >> 32);
      end
      return tab;
   endfunction

   localparam power_table_type POWER_TABLE = build_power_table();

endpackage

`default_nettype wire

### src/bfg_mul.sv
// Shared registered multiplier of the fuel gauge datapath.
// Depends on bfg_pkg for operand widths.
`default_nettype none

module bfg_mul (
   input  wire logic                      clock,
   input  wire logic                      mul_en,
   input  wire logic [bfg_pkg::A_W-1:0]   mul_a,
   input  wire logic [bfg_pkg::B_W-1:0]   mul_b,
   output logic      [bfg_pkg::P_W-1:0]   mul_prod
);

   logic [bfg_pkg::P_W-1:0] prod_ff;
   logic [bfg_pkg::P_W-1:0] prod_in;

   // Product holds until the next issue
   always_comb begin
      prod_in = prod_ff;
      if (mul_en) begin
         prod_in = bfg_pkg::P_W'(mul_a) * bfg_pkg::P_W'(mul_b);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_prod = prod_ff;

endmodule

`default_nettype wire

### src/bfg_div.sv
// Bit-serial restoring divider for the charge drain.
// Depends on bfg_pkg for widths and the request/response structs.
`default_nettype none

module bfg_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bfg_pkg::div_req_type  div_req,
   output bfg_pkg::div_rsp_type       div_rsp
);

   localparam int N = bfg_pkg::DIVIDEND_W;
   localparam int D = bfg_pkg::DIVISOR_W;
   localparam int C = bfg_pkg::DIV_CNT_W;

   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [C-1:0] count_ff, count_in;
   logic [D-1:0] rem_ff, rem_in;
   logic [N-1:0] quo_ff, quo_in;
   logic [D-1:0] divisor_ff, divisor_in;

   logic [D:0]   shifted;
   logic [D+1:0] trial;
   logic         ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[N-1]};
      trial = {1'b0, shifted} - {2'b00, divisor_ff};
      ge = !trial[D+1];

      busy_in = busy_ff;
      done_in = 1'b0;
      count_in = count_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      divisor_in = divisor_ff;

      if (div_req.start) begin
         busy_in = 1'b1;
         count_in = '0;
         rem_in = '0;
         quo_in = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         // partial remainder stays below the divisor, so D bits hold it
         rem_in = ge ? trial[D-1:0] : shifted[D-1:0];
         quo_in = {quo_ff[N-2:0], ge};
         count_in = count_ff + C'(1);
         if (count_ff == C'(N - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire

### src/battery_fuel_gauge_model.sv
// Battery fuel gauge top level: request sequencer, charge state and CSRs.
// Depends on bfg_pkg, bfg_mul and bfg_div.
`default_nettype none

// Each request (pack current, time step) returns the terminal voltage at the charge
// held before the tick, then the charge after a current^1.1 drain, and an empty flag.
// A draining request runs the sequencer steps on the shared 25x24 multiplier, waits
// on the bit-serial divider for the 53-bit drain quotient, and then loads the output
// register; the next request is taken only once the sequencer is back in idle. With
// no drain (current not positive or zero step) the table steps and the division are
// skipped. The voltage is rounded by a reciprocal multiply, not a division. req_tready
// is high while the sequencer is idle; a finished response waits in the output register
// while the next request is taken, and the sequencer holds its next result until that
// register is free. CSR writes are accepted every cycle and should be issued only while
// no request is in flight.

module battery_fuel_gauge_model (
   input  wire logic        clock,
   input  wire logic        reset,
   // request: current_draw [15:0], step_us [35:16], zero pad [39:36]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,
   // response: terminal_mv [13:0], charge_level [38:14], zero pad [39]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,
   // response: pack_empty [0]
   output logic [0:0]       rsp_tuser,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [bfg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bfg_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_OCV    = 4'd1;
   localparam logic [3:0] ST_SAG    = 4'd2;
   localparam logic [3:0] ST_TERM   = 4'd3;
   localparam logic [3:0] ST_MV     = 4'd4;
   localparam logic [3:0] ST_TAB    = 4'd5;
   localparam logic [3:0] ST_INTERP = 4'd6;
   localparam logic [3:0] ST_PEUK   = 4'd7;
   localparam logic [3:0] ST_DT     = 4'd8;
   localparam logic [3:0] ST_CAP    = 4'd9;
   localparam logic [3:0] ST_DEN    = 4'd10;
   localparam logic [3:0] ST_DDIV   = 4'd11;
   localparam logic [3:0] ST_DONE   = 4'd12;
   localparam logic [3:0] ST_RECIP  = 4'd13;

   localparam int A_W = bfg_pkg::A_W;
   localparam int B_W = bfg_pkg::B_W;
   localparam int P_W = bfg_pkg::P_W;
   localparam int Y_W = bfg_pkg::Y_W;
   localparam int N = bfg_pkg::DIVIDEND_W;
   localparam int D = bfg_pkg::DIVISOR_W;
   localparam int CHG_W = bfg_pkg::CHG_W;
   localparam int OCV_W = bfg_pkg::OCV_W;
   localparam int IDX_W = bfg_pkg::IDX_W;

   logic [3:0]                   state_ff, state_in;
   logic [bfg_pkg::CUR_W-1:0]    cur_ff, cur_in;
   logic [bfg_pkg::DT_W-1:0]     dt_ff, dt_in;
   logic [CHG_W-1:0]             c_ff, c_in;
   logic [CHG_W-1:0]             charge_ff, charge_in;
   logic                         hi_ff, hi_in;
   logic [OCV_W-1:0]             ocv_ff, ocv_in;
   logic [B_W-1:0]               round_ff, round_in;
   logic [bfg_pkg::MV_W-1:0]     mv_ff, mv_in;
   logic [14:0]                  frac_ff, frac_in;
   logic [Y_W-1:0]               y0_ff, y0_in;
   logic [Y_W-1:0]               d_ff, d_in;
   logic [Y_W-1:0]               p_ff, p_in;
   logic [N-1:0]                 num_ff, num_in;
   logic [bfg_pkg::RES_W-1:0]    res_ff, res_in;
   logic [bfg_pkg::CAP_W-1:0]    cap_ff, cap_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [bfg_pkg::MV_W-1:0]     rsp_mv_ff, rsp_mv_in;
   logic [CHG_W-1:0]             rsp_charge_ff, rsp_charge_in;
   logic                         rsp_empty_ff, rsp_empty_in;

   logic                         mul_en;
   logic [A_W-1:0]               mul_a;
   logic [B_W-1:0]               mul_b;
   logic [P_W-1:0]               mul_prod;
   bfg_pkg::div_req_type         div_req;
   bfg_pkg::div_rsp_type         div_rsp;

   logic                         req_fire;
   logic                         cur_pos;
   logic                         drain;
   logic                         hi_now;
   logic [CHG_W+2:0]             c_times5;
   logic [51:0]                  sag;
   logic [OCV_W-1:0]             term;
   logic [OCV_W-1:0]             mv_sum;
   logic [IDX_W-1:0]             seg;
   logic [Y_W-1:0]               y0_rd;
   logic [Y_W-1:0]               y1_rd;
   logic [D-1:0]                 den;
   logic [bfg_pkg::CAP_W-1:0]    cap_eff;
   logic                         out_free;

   bfg_mul u_mul (
      .clock    (clock),
      .mul_en   (mul_en),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .mul_prod (mul_prod)
   );

   bfg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   assign cur_pos = !cur_ff[bfg_pkg::CUR_W-1] && (cur_ff != '0);
   assign drain = cur_pos && (dt_ff != '0);

   // upper OCV segment when charge is above one fifth
   assign c_times5 = {3'b000, c_ff} + {1'b0, c_ff, 2'b00};
   assign hi_now = c_times5 > {3'b000, bfg_pkg::FULL_CHARGE};

   assign sag = {mul_prod[35:0], 16'h0000};
   assign term = ({4'h0, ocv_ff} > sag) ? (ocv_ff - sag[OCV_W-1:0]) : '0;
   assign mv_sum = term + bfg_pkg::MV_HALF;

   assign seg = mul_prod[15 +: IDX_W];
   assign y0_rd = bfg_pkg::POWER_TABLE[seg];
   assign y1_rd = bfg_pkg::POWER_TABLE[seg + IDX_W'(1)];

   assign den = mul_prod[D-1:0];
   assign cap_eff = (cap_ff == '0) ? bfg_pkg::CAP_W'(1) : cap_ff;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // multiplier and divider issue
   always_comb begin
      mul_en = 1'b0;
      mul_a = '0;
      mul_b = '0;
      div_req.start = 1'b0;
      div_req.dividend = '0;
      div_req.divisor = '0;
      case (state_ff)
         ST_OCV: begin
            mul_en = 1'b1;
            mul_a = c_ff;
            mul_b = hi_now ? bfg_pkg::OCV_SLOPE_HI : bfg_pkg::OCV_SLOPE_LO;
         end
         ST_SAG: begin
            mul_en = 1'b1;
            mul_a = {5'b00000, res_ff};
            mul_b = cur_pos ? {9'h000, cur_ff[14:0]} : '0;
         end
         ST_RECIP: begin
            mul_en = 1'b1;
            mul_a = bfg_pkg::MV_RECIP;
            mul_b = round_ff;
         end
         ST_MV: begin
            mul_en = 1'b1;
            mul_a = {10'h000, cur_ff[14:0]};
            mul_b = B_W'(bfg_pkg::POWER_TABLE_SEGMENTS);
         end
         ST_INTERP: begin
            mul_en = 1'b1;
            mul_a = {1'b0, d_ff};
            mul_b = {9'h000, frac_ff};
         end
         ST_DT: begin
            mul_en = 1'b1;
            mul_a = {1'b0, p_ff};
            mul_b = {4'h0, dt_ff};
         end
         ST_CAP: begin
            mul_en = 1'b1;
            mul_a = bfg_pkg::HOUR_MS;
            mul_b = {8'h00, cap_eff};
         end
         ST_DEN: begin
            // rounding half up: add half the divisor
            div_req.start = 1'b1;
            div_req.dividend = num_ff + {16'h0000, den[D-1:1]};
            div_req.divisor = den;
         end
         default: begin
         end
      endcase
   end

   // sequencer and datapath registers
   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      dt_in = dt_ff;
      c_in = c_ff;
      charge_in = charge_ff;
      hi_in = hi_ff;
      ocv_in = ocv_ff;
      round_in = round_ff;
      mv_in = mv_ff;
      frac_in = frac_ff;
      y0_in = y0_ff;
      d_in = d_ff;
      p_in = p_ff;
      num_in = num_ff;
      res_in = res_ff;
      cap_in = cap_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_mv_in = rsp_mv_ff;
      rsp_charge_in = rsp_charge_ff;
      rsp_empty_in = rsp_empty_ff;

      if (csr_valid) begin
         if (csr_index == bfg_pkg::CSR_RESISTANCE) begin
            res_in = csr_data[bfg_pkg::RES_W-1:0];
         end else if (csr_index == bfg_pkg::CSR_CAPACITY) begin
            cap_in = csr_data[bfg_pkg::CAP_W-1:0];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cur_in = req_tdata[15:0];
               dt_in = req_tdata[35:16];
               c_in = charge_ff;
               state_in = ST_OCV;
            end
         end
         ST_OCV: begin
            hi_in = hi_now;
            state_in = ST_SAG;
         end
         ST_SAG: begin
            ocv_in = (hi_ff ? bfg_pkg::OCV_BASE_HI : bfg_pkg::OCV_BASE_LO)
                     + mul_prod[OCV_W-1:0];
            state_in = ST_TERM;
         end
         ST_TERM: begin
            round_in = mv_sum[OCV_W-1:24];
            state_in = ST_RECIP;
         end
         ST_RECIP: begin
            state_in = ST_MV;
         end
         ST_MV: begin
            mv_in = mul_prod[bfg_pkg::MV_RECIP_SHIFT +: bfg_pkg::MV_W];
            state_in = drain ? ST_TAB : ST_DONE;
         end
         ST_TAB: begin
            frac_in = mul_prod[14:0];
            y0_in = y0_rd;
            d_in = (y1_rd > y0_rd) ? (y1_rd - y0_rd) : '0;
            state_in = ST_INTERP;
         end
         ST_INTERP: begin
            state_in = ST_PEUK;
         end
         ST_PEUK: begin
            p_in = y0_ff + mul_prod[15 +: Y_W];
            state_in = ST_DT;
         end
         ST_DT: begin
            state_in = ST_CAP;
         end
         ST_CAP: begin
            num_in = {1'b0, mul_prod[43:0], 8'h00};
            state_in = ST_DEN;
         end
         ST_DEN: begin
            state_in = ST_DDIV;
         end
         ST_DDIV: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient >= {28'h0, c_ff}) begin
                  c_in = '0;
               end else begin
                  c_in = c_ff - div_rsp.quotient[CHG_W-1:0];
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_mv_in = mv_ff;
               rsp_charge_in = c_ff;
               rsp_empty_in = (c_ff == '0);
               charge_in = c_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         charge_ff <= bfg_pkg::FULL_CHARGE;
         res_ff <= 20'd30000;
         cap_ff <= 16'd3000;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         charge_ff <= charge_in;
         res_ff <= res_in;
         cap_ff <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      dt_ff <= dt_in;
      c_ff <= c_in;
      hi_ff <= hi_in;
      ocv_ff <= ocv_in;
      round_ff <= round_in;
      mv_ff <= mv_in;
      frac_ff <= frac_in;
      y0_ff <= y0_in;
      d_ff <= d_in;
      p_ff <= p_in;
      num_ff <= num_in;
      rsp_mv_ff <= rsp_mv_in;
      rsp_charge_ff <= rsp_charge_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {1'b0, rsp_charge_ff, rsp_mv_ff};
   assign rsp_tuser = rsp_empty_ff;

endmodule

`default_nettype wire
